>>> rtl/core/orbit_camera_position_defines.svh
// ---------------------------------------------------------------------------
// orbit camera position assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef ORBIT_CAMERA_POSITION_DEFINES_SVH
`define ORBIT_CAMERA_POSITION_DEFINES_SVH

// same-cycle implication, quiet during reset
`define OCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define OCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ocp_pkg.sv
// ---------------------------------------------------------------------------
// orbit camera position package
// shared widths, constants, key codes and the cordic arctangent table
// ---------------------------------------------------------------------------
package ocp_pkg;

   localparam int CORDIC_ITER_DEF = 16;
   localparam int CORDIC_W        = 36;

   localparam logic signed [CORDIC_W-1:0] PI_Q30      = CORDIC_W'(64'd3373259426);
   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = CORDIC_W'(64'd1686629713);
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = CORDIC_W'(64'd652032874);

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_KEY     = 2'd1;
   localparam logic [1:0] KIND_SPECIAL = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   localparam logic [7:0] KEY_W_LO  = 8'h77;
   localparam logic [7:0] KEY_W_UP  = 8'h57;
   localparam logic [7:0] KEY_S_LO  = 8'h73;
   localparam logic [7:0] KEY_S_UP  = 8'h53;
   localparam logic [7:0] KEY_D_LO  = 8'h64;
   localparam logic [7:0] KEY_D_UP  = 8'h44;
   localparam logic [7:0] KEY_A_LO  = 8'h61;
   localparam logic [7:0] KEY_A_UP  = 8'h41;
   localparam logic [7:0] KEY_LEFT  = 8'd100;
   localparam logic [7:0] KEY_UP    = 8'd101;
   localparam logic [7:0] KEY_RIGHT = 8'd102;
   localparam logic [7:0] KEY_DOWN  = 8'd103;

   localparam logic [2:0] REG_ZOOM_STEP       = 3'd0;
   localparam logic [2:0] REG_ANGLE_STEP      = 3'd1;
   localparam logic [2:0] REG_PITCH_LIMIT     = 3'd2;
   localparam logic [2:0] REG_MIN_RADIUS      = 3'd3;
   localparam logic [2:0] REG_LOAD_MIN_RADIUS = 3'd4;

   localparam logic [30:0] ZOOM_STEP_RST       = 31'd327680;
   localparam logic [14:0] ANGLE_STEP_RST      = 15'd819;
   localparam logic [13:0] PITCH_LIMIT_RST     = 14'd12288;
   localparam logic [30:0] MIN_RADIUS_RST      = 31'd65536;
   localparam logic [30:0] LOAD_MIN_RADIUS_RST = 31'd6554;
   localparam logic [30:0] RADIUS_RST          = 31'd65536;
   localparam logic [30:0] MAX31               = 31'h7FFFFFFF;

   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

   typedef struct packed {
      logic start;
      logic vector_mode;
   } ocp_cordic_ctl_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      unique case (idx)
         5'd0:  return 30'd843314856;
         5'd1:  return 30'd497837829;
         5'd2:  return 30'd263043836;
         5'd3:  return 30'd133525158;
         5'd4:  return 30'd67021686;
         5'd5:  return 30'd33543515;
         5'd6:  return 30'd16775850;
         5'd7:  return 30'd8388437;
         5'd8:  return 30'd4194282;
         5'd9:  return 30'd2097149;
         5'd10: return 30'd1048575;
         5'd11: return 30'd524287;
         5'd12: return 30'd262143;
         5'd13: return 30'd131071;
         5'd14: return 30'd65535;
         5'd15: return 30'd32767;
         5'd16: return 30'd16383;
         5'd17: return 30'd8191;
         5'd18: return 30'd4095;
         5'd19: return 30'd2047;
         5'd20: return 30'd1023;
         5'd21: return 30'd511;
         5'd22: return 30'd255;
         5'd23: return 30'd127;
         5'd24: return 30'd63;
         5'd25: return 30'd31;
         5'd26: return 30'd15;
         5'd27: return 30'd7;
         5'd28: return 30'd3;
         5'd29: return 30'd1;
         default: return 30'd0;
      endcase
   endfunction

endpackage

>>> rtl/core/ocp_sqrt.sv
// ---------------------------------------------------------------------------
// ocp square root unit
// 64-bit integer square root, one result bit retired per cycle, 32 steps
// ---------------------------------------------------------------------------
module ocp_sqrt
   import ocp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] rem_ff, res_ff, one_ff, trial;
   logic [4:0]  step_ff;
   logic        busy_ff, done_ff;

   assign trial = res_ff + one_ff;
   assign done  = done_ff;
   assign root  = res_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start && (step_ff == 5'd31);
         if (start) begin
            rem_ff  <= value;
            res_ff  <= '0;
            one_ff  <= 64'h4000_0000_0000_0000;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               res_ff <= (res_ff >> 1) + one_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            one_ff  <= one_ff >> 2;
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

endmodule

>>> rtl/core/ocp_cordic.sv
// ---------------------------------------------------------------------------
// ocp cordic unit
// shared rotation (sine, cosine) and vectoring (arctangent) engine
// ---------------------------------------------------------------------------
module ocp_cordic
   import ocp_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  ocp_cordic_ctl_type         ctl,
   input  logic signed [15:0]         angle,
   input  logic signed [CORDIC_W-1:0] vec_x,
   input  logic signed [CORDIC_W-1:0] vec_y,
   output logic                       done,
   output logic signed [CORDIC_W-1:0] cos_out,
   output logic signed [CORDIC_W-1:0] sin_out,
   output logic signed [15:0]         angle_out
);

   localparam int IW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff;
   logic signed [CORDIC_W-1:0] xs, ys, at, x_nx, y_nx, z_nx, z_ang, z_rnd;
   logic [IW-1:0]              iter_ff;
   logic                       busy_ff, done_ff, vec_ff, neg_ff, zero_ff, dir;

   assign z_ang = $signed({{(CORDIC_W-33){angle[15]}}, angle, 17'd0});
   assign xs    = x_ff >>> iter_ff;
   assign ys    = y_ff >>> iter_ff;
   assign at    = $signed({{(CORDIC_W-30){1'b0}}, atan_q30(5'(iter_ff))});
   // rotate toward zero residual angle, or toward zero y when vectoring
   assign dir   = vec_ff ? y_ff[CORDIC_W-1] : !z_ff[CORDIC_W-1];
   assign x_nx  = dir ? x_ff - ys : x_ff + ys;
   assign y_nx  = dir ? y_ff + xs : y_ff - xs;
   assign z_nx  = dir ? z_ff - at : z_ff + at;
   assign z_rnd = (z_nx + CORDIC_W'(65536)) >>> 17;
   assign done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= !ctl.start && busy_ff && (iter_ff == IW'(CORDIC_ITERATIONS - 1));
         if (ctl.start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
            vec_ff  <= ctl.vector_mode;
            zero_ff <= (vec_x == '0) && (vec_y == '0);
            if (ctl.vector_mode) begin
               neg_ff <= 1'b0;
               if (vec_x[CORDIC_W-1] && !vec_y[CORDIC_W-1]) begin
                  x_ff <= vec_y;
                  y_ff <= -vec_x;
                  z_ff <= HALF_PI_Q30;
               end else if (vec_x[CORDIC_W-1]) begin
                  x_ff <= -vec_y;
                  y_ff <= vec_x;
                  z_ff <= -HALF_PI_Q30;
               end else begin
                  x_ff <= vec_x;
                  y_ff <= vec_y;
                  z_ff <= '0;
               end
            end else begin
               x_ff <= GAIN_Q30;
               y_ff <= '0;
               if (z_ang > HALF_PI_Q30) begin
                  z_ff   <= z_ang - PI_Q30;
                  neg_ff <= 1'b1;
               end else if (z_ang < -HALF_PI_Q30) begin
                  z_ff   <= z_ang + PI_Q30;
                  neg_ff <= 1'b1;
               end else begin
                  z_ff   <= z_ang;
                  neg_ff <= 1'b0;
               end
            end
         end else if (busy_ff) begin
            x_ff    <= x_nx;
            y_ff    <= y_nx;
            z_ff    <= z_nx;
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == IW'(CORDIC_ITERATIONS - 1)) begin
               busy_ff   <= 1'b0;
               cos_out   <= neg_ff ? -x_nx : x_nx;
               sin_out   <= neg_ff ? -y_nx : y_nx;
               angle_out <= zero_ff ? 16'sd0 : z_rnd[15:0];
            end
         end
      end
   end

endmodule

>>> rtl/core/orbit_camera_position.sv
// a load word needs two 32-step square roots and four cordic runs
// throughput: one word at a time; the shared cordic engine, square root unit and
//   one 33x33 multiplier limit the pace; a waiting result does not block acceptance
// reset: synchronous active high; radius 1.0, yaw and pitch zero, registers at defaults
// ---------------------------------------------------------------------------
// orbit camera position
// sequencer keeping radius, yaw and pitch and producing the cartesian position
// ---------------------------------------------------------------------------
module orbit_camera_position
   import ocp_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_key_code,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_cam_x,
   output logic signed [31:0] rsp_cam_y,
   output logic signed [31:0] rsp_cam_z,
   output logic [30:0]        rsp_out_radius,
   output logic signed [15:0] rsp_out_yaw,
   output logic signed [14:0] rsp_out_pitch,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LD_MX, ST_LD_MY, ST_LD_MZ, ST_LD_ACC, ST_LD_SQ1, ST_LD_RR,
      ST_LD_DIFF, ST_LD_SQ2, ST_LD_YAW, ST_LD_PIT, ST_KEY, ST_ROT_P, ST_ROT_Y,
      ST_MUL_H, ST_MUL_Y, ST_MUL_X, ST_MUL_Z, ST_FIN, ST_WR
   } state_type;

   state_type state_ff;

   logic [30:0] zoom_step_ff, min_radius_ff, load_min_ff;
   logic [14:0] angle_step_ff;
   logic [13:0] pitch_limit_ff;

   logic [1:0]         kind_ff;
   logic [7:0]         key_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [30:0]        radius_ff;
   logic signed [15:0] yaw_ff;
   logic signed [14:0] pitch_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;
   logic [63:0]        acc_ff, yy_ff, sq_arg_ff, rr;
   logic [31:0]        hz_ff;
   logic signed [32:0] cp_ff, sp_ff, cy_ff, sy_ff, h_ff;
   logic signed [31:0] camx_ff, camy_ff, camz_ff;
   logic signed [65:0] h_full;
   logic               rsp_valid_ff;

   logic                       sq_start_ff, sq_done, sq_start;
   logic [31:0]                sq_root;
   logic [30:0]                r_sat, r_load;
   ocp_cordic_ctl_type         cor_ctl_ff;
   logic                       cor_start, cor_vec;
   logic signed [15:0]         cor_ang_ff, cor_angle;
   logic signed [CORDIC_W-1:0] cor_vx_ff, cor_vy_ff, cor_cos, cor_sin;
   logic                       cor_done;

   logic [30:0]        key_radius;
   logic signed [15:0] key_yaw;
   logic signed [14:0] key_pitch;
   logic [31:0]        r_add;
   logic signed [17:0] st_s, lim_s, pit_sum, ld_pitch;

   function automatic logic signed [31:0] sat_rs30(input logic signed [65:0] p);
      logic signed [65:0] s;
      s = (p + 66'sd536870912) >>> 30;
      if (s > 66'sd2147483647) return 32'sh7FFF_FFFF;
      else if (s < -66'sd2147483648) return 32'sh8000_0000;
      else return s[31:0];
   endfunction

   function automatic logic signed [15:0] wrap_yaw(input logic signed [17:0] a);
      if (a > PI_Q13) return 16'(a - TWO_PI_Q13);
      else if (a < -PI_Q13) return 16'(a + TWO_PI_Q13);
      else return a[15:0];
   endfunction

   ocp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start_ff),
      .value (sq_arg_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   ocp_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cor_ctl_ff),
      .angle     (cor_ang_ff),
      .vec_x     (cor_vx_ff),
      .vec_y     (cor_vy_ff),
      .done      (cor_done),
      .cos_out   (cor_cos),
      .sin_out   (cor_sin),
      .angle_out (cor_angle)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rr        = prod_ff[63:0];
   assign h_full    = (prod_ff + 66'sd536870912) >>> 30;
   assign r_sat     = (sq_root > {1'b0, MAX31}) ? MAX31 : sq_root[30:0];
   assign r_load    = (r_sat < load_min_ff) ? load_min_ff : r_sat;
   assign ld_pitch  = (18'(cor_angle) > HALF_PI_Q13) ? HALF_PI_Q13 :
                      (18'(cor_angle) < -HALF_PI_Q13) ? -HALF_PI_Q13 : 18'(cor_angle);
   assign st_s      = $signed({3'b000, angle_step_ff});
   assign lim_s     = $signed({4'b0000, pitch_limit_ff});
   assign r_add     = {1'b0, radius_ff} + {1'b0, zoom_step_ff};

   // unit start strobes
   assign sq_start  = (state_ff == ST_LD_ACC) || (state_ff == ST_LD_DIFF);
   assign cor_start = (state_ff == ST_KEY) || ((state_ff == ST_LD_SQ2) && sq_done) ||
                      (((state_ff == ST_LD_YAW) || (state_ff == ST_LD_PIT) ||
                        (state_ff == ST_ROT_P)) && cor_done);
   assign cor_vec   = (state_ff == ST_LD_SQ2) || (state_ff == ST_LD_YAW);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LD_MX: begin
            mul_a = 33'(px_ff);
            mul_b = 33'(px_ff);
         end
         ST_LD_MY: begin
            mul_a = 33'(py_ff);
            mul_b = 33'(py_ff);
         end
         ST_LD_MZ: begin
            mul_a = 33'(pz_ff);
            mul_b = 33'(pz_ff);
         end
         ST_LD_RR: begin
            mul_a = $signed({2'b00, radius_ff});
            mul_b = $signed({2'b00, radius_ff});
         end
         ST_MUL_H: begin
            mul_a = $signed({2'b00, radius_ff});
            mul_b = cp_ff;
         end
         ST_MUL_Y: begin
            mul_a = $signed({2'b00, radius_ff});
            mul_b = sp_ff;
         end
         ST_MUL_X: begin
            mul_a = h_ff;
            mul_b = sy_ff;
         end
         ST_MUL_Z: begin
            mul_a = h_ff;
            mul_b = cy_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // key update
   always_comb begin
      key_radius = radius_ff;
      key_yaw    = yaw_ff;
      key_pitch  = pitch_ff;
      pit_sum    = 18'(pitch_ff);
      unique case (kind_ff)
         KIND_KEY: begin
            priority if (key_ff == KEY_W_LO || key_ff == KEY_W_UP)
               key_radius = (radius_ff > zoom_step_ff) ? radius_ff - zoom_step_ff : '0;
            else if (key_ff == KEY_S_LO || key_ff == KEY_S_UP)
               key_radius = r_add[31] ? MAX31 : r_add[30:0];
            else if (key_ff == KEY_D_LO || key_ff == KEY_D_UP)
               key_yaw = wrap_yaw(18'(yaw_ff) + st_s);
            else if (key_ff == KEY_A_LO || key_ff == KEY_A_UP)
               key_yaw = wrap_yaw(18'(yaw_ff) - st_s);
            else
               key_radius = radius_ff;
            if (key_radius < min_radius_ff) key_radius = min_radius_ff;
         end
         KIND_SPECIAL: begin
            priority if (key_ff == KEY_RIGHT) key_yaw = wrap_yaw(18'(yaw_ff) + st_s);
            else if (key_ff == KEY_LEFT) key_yaw = wrap_yaw(18'(yaw_ff) - st_s);
            else if (key_ff == KEY_UP) pit_sum = 18'(pitch_ff) + st_s;
            else if (key_ff == KEY_DOWN) pit_sum = 18'(pitch_ff) - st_s;
            else pit_sum = 18'(pitch_ff);
            if (pit_sum > lim_s) pit_sum = lim_s;
            if (pit_sum < -lim_s) pit_sum = -lim_s;
            key_pitch = pit_sum[14:0];
         end
         KIND_LOAD, KIND_NONE: begin
            key_radius = radius_ff;
         end
         default: key_radius = radius_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_step_ff   <= ZOOM_STEP_RST;
         angle_step_ff  <= ANGLE_STEP_RST;
         pitch_limit_ff <= PITCH_LIMIT_RST;
         min_radius_ff  <= MIN_RADIUS_RST;
         load_min_ff    <= LOAD_MIN_RADIUS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ZOOM_STEP:       zoom_step_ff   <= csr_wdata;
            REG_ANGLE_STEP:      angle_step_ff  <= csr_wdata[14:0];
            REG_PITCH_LIMIT:     pitch_limit_ff <= csr_wdata[13:0];
            REG_MIN_RADIUS:      min_radius_ff  <= csr_wdata;
            REG_LOAD_MIN_RADIUS: load_min_ff    <= csr_wdata;
            default:             zoom_step_ff   <= zoom_step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RST;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sq_start_ff  <= 1'b0;
         cor_ctl_ff   <= '0;
      end else begin
         sq_start_ff <= sq_start;
         cor_ctl_ff  <= '{start: cor_start, vector_mode: cor_vec};
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_WR)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_kind;
                  key_ff   <= req_key_code;
                  px_ff    <= req_pos_x;
                  py_ff    <= req_pos_y;
                  pz_ff    <= req_pos_z;
                  state_ff <= (req_kind == KIND_LOAD) ? ST_LD_MX : ST_KEY;
               end
            end
            ST_LD_MX: state_ff <= ST_LD_MY;
            ST_LD_MY: begin
               acc_ff   <= prod_ff[63:0];
               state_ff <= ST_LD_MZ;
            end
            ST_LD_MZ: begin
               acc_ff   <= acc_ff + prod_ff[63:0];
               yy_ff    <= prod_ff[63:0];
               state_ff <= ST_LD_ACC;
            end
            ST_LD_ACC: begin
               sq_arg_ff <= acc_ff + prod_ff[63:0];
               state_ff  <= ST_LD_SQ1;
            end
            ST_LD_SQ1: begin
               if (sq_done) begin
                  radius_ff <= r_load;
                  state_ff  <= ST_LD_RR;
               end
            end
            ST_LD_RR: state_ff <= ST_LD_DIFF;
            ST_LD_DIFF: begin
               sq_arg_ff <= (rr > yy_ff) ? rr - yy_ff : '0;
               state_ff  <= ST_LD_SQ2;
            end
            ST_LD_SQ2: begin
               if (sq_done) begin
                  hz_ff     <= sq_root;
                  cor_vx_ff <= CORDIC_W'(pz_ff);
                  cor_vy_ff <= CORDIC_W'(px_ff);
                  state_ff  <= ST_LD_YAW;
               end
            end
            ST_LD_YAW: begin
               if (cor_done) begin
                  yaw_ff    <= cor_angle;
                  cor_vx_ff <= $signed({{(CORDIC_W-32){1'b0}}, hz_ff});
                  cor_vy_ff <= CORDIC_W'(py_ff);
                  state_ff  <= ST_LD_PIT;
               end
            end
            ST_LD_PIT: begin
               if (cor_done) begin
                  pitch_ff   <= ld_pitch[14:0];
                  cor_ang_ff <= ld_pitch[15:0];
                  state_ff   <= ST_ROT_P;
               end
            end
            ST_KEY: begin
               radius_ff  <= key_radius;
               yaw_ff     <= key_yaw;
               pitch_ff   <= key_pitch;
               cor_ang_ff <= 16'(key_pitch);
               state_ff   <= ST_ROT_P;
            end
            ST_ROT_P: begin
               if (cor_done) begin
                  cp_ff      <= cor_cos[32:0];
                  sp_ff      <= cor_sin[32:0];
                  cor_ang_ff <= yaw_ff;
                  state_ff   <= ST_ROT_Y;
               end
            end
            ST_ROT_Y: begin
               if (cor_done) begin
                  cy_ff    <= cor_cos[32:0];
                  sy_ff    <= cor_sin[32:0];
                  state_ff <= ST_MUL_H;
               end
            end
            ST_MUL_H: state_ff <= ST_MUL_Y;
            ST_MUL_Y: begin
               h_ff     <= h_full[32:0];
               state_ff <= ST_MUL_X;
            end
            ST_MUL_X: begin
               camy_ff  <= sat_rs30(prod_ff);
               state_ff <= ST_MUL_Z;
            end
            ST_MUL_Z: begin
               camx_ff  <= sat_rs30(prod_ff);
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               camz_ff  <= sat_rs30(prod_ff);
               state_ff <= ST_WR;
            end
            ST_WR: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_cam_x      <= camx_ff;
                  rsp_cam_y      <= camy_ff;
                  rsp_cam_z      <= camz_ff;
                  rsp_out_radius <= radius_ff;
                  rsp_out_yaw    <= yaw_ff;
                  rsp_out_pitch  <= pitch_ff;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/core/ocp_checker.sv
// ---------------------------------------------------------------------------
// ocp port checker
// watches the top-level ports of the orbit camera position block
// ---------------------------------------------------------------------------
`include "orbit_camera_position_defines.svh"

module ocp_checker
   import ocp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_kind,
   input logic [7:0]         req_key_code,
   input logic signed [31:0] req_pos_x,
   input logic signed [31:0] req_pos_y,
   input logic signed [31:0] req_pos_z,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_cam_x,
   input logic signed [31:0] rsp_cam_y,
   input logic signed [31:0] rsp_cam_z,
   input logic [30:0]        rsp_out_radius,
   input logic signed [15:0] rsp_out_yaw,
   input logic signed [14:0] rsp_out_pitch,
   input logic               csr_we,
   input logic [2:0]         csr_index,
   input logic [30:0]        csr_wdata
);

   // a stalled result word holds
   `OCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_cam_x) && $stable(rsp_out_radius), "result word changed while stalled")

   // an accepted word keeps the sequencer busy on the next cycle
   `OCP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      !req_ready, "ready right after accepting a word")

   // no result straight out of reset
   `OCP_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // yaw stays wrapped near plus or minus pi
   `OCP_ASSERT_NOW(a_yaw_range, clock, reset, rsp_valid,
      (rsp_out_yaw <= 16'sd26000) && (rsp_out_yaw >= -16'sd26000), "yaw out of range")

endmodule

bind orbit_camera_position ocp_checker u_ocp_checker (.*);

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// orbit camera position testbench
// drives load, key, special-key and none-kind words with random gaps and result stalls,
// predicts radius, yaw, pitch and the cartesian position with a cordic model
// and checks every result word field by field across several register settings
// ---------------------------------------------------------------------------
module testbench;
   import ocp_pkg::*;

   localparam int  ITERS     = CORDIC_ITER_DEF;
   localparam int  LIMIT     = 3000000;
   localparam int  SETTLE    = 200;

   typedef struct {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic [30:0]        radius;
      logic signed [15:0] yaw;
      logic signed [14:0] pitch;
   } pose_type;

   typedef struct {
      logic [1:0]         kind;
      logic [7:0]         key;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } cmd_type;

   class camera_scoreboard;
      pose_type pending[$];
      int      errors;
      longint  zoom_step, angle_step, pitch_limit, min_radius, load_min_radius;
      longint  radius;
      int      yaw, pitch;

      function new();
         errors = 0;
         zoom_step = ZOOM_STEP_RST; angle_step = ANGLE_STEP_RST;
         pitch_limit = PITCH_LIMIT_RST; min_radius = MIN_RADIUS_RST;
         load_min_radius = LOAD_MIN_RADIUS_RST;
         radius = RADIUS_RST; yaw = 0; pitch = 0;
      endfunction

      function longint rshift_round(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, one;
         res = 0;
         one = 64'd1 << 62;
         while (one > v) one = one >> 2;
         while (one != 0) begin
            if (v >= res + one) begin
               v = v - (res + one);
               res = (res >> 1) + one;
            end else begin
               res = res >> 1;
            end
            one = one >> 2;
         end
         return res;
      endfunction

      function void rotate(int ang, output longint c, output longint s);
         longint z, x, y, t;
         bit     neg;
         z = longint'(ang) * 131072;
         x = longint'(GAIN_Q30);
         y = 0;
         neg = 0;
         if (z > longint'(HALF_PI_Q30)) begin
            z = z - longint'(PI_Q30); neg = 1;
         end else if (z < -longint'(HALF_PI_Q30)) begin
            z = z + longint'(PI_Q30); neg = 1;
         end
         for (int i = 0; i < ITERS; i++) begin
            if (z >= 0) begin
               t = x - (y >>> i); y = y + (x >>> i); z = z - longint'(atan_q30(i[4:0]));
            end else begin
               t = x + (y >>> i); y = y - (x >>> i); z = z + longint'(atan_q30(i[4:0]));
            end
            x = t;
         end
         if (neg) begin
            x = -x; y = -y;
         end
         c = x;
         s = y;
      endfunction

      function int heading(longint x, longint y);
         longint z, t;
         z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = y; y = -x; x = t; z = longint'(HALF_PI_Q30);
            end else begin
               t = -y; y = x; x = t; z = -longint'(HALF_PI_Q30);
            end
         end
         for (int i = 0; i < ITERS; i++) begin
            if (y >= 0) begin
               t = x + (y >>> i); y = y - (x >>> i); z = z + longint'(atan_q30(i[4:0]));
            end else begin
               t = x - (y >>> i); y = y + (x >>> i); z = z - longint'(atan_q30(i[4:0]));
            end
            x = t;
         end
         return int'(rshift_round(z, 17));
      endfunction

      function int wrap(int a);
         if (a > int'(PI_Q13)) a = a - int'(TWO_PI_Q13);
         else if (a < -int'(PI_Q13)) a = a + int'(TWO_PI_Q13);
         return a;
      endfunction

      function void set_reg(logic [2:0] idx, longint v);
         case (idx)
            REG_ZOOM_STEP:       zoom_step = v & 64'h7FFFFFFF;
            REG_ANGLE_STEP:      angle_step = v & 64'h7FFF;
            REG_PITCH_LIMIT:     pitch_limit = v & 64'h3FFF;
            REG_MIN_RADIUS:      min_radius = v & 64'h7FFFFFFF;
            REG_LOAD_MIN_RADIUS: load_min_radius = v & 64'h7FFFFFFF;
            default: ;
         endcase
      endfunction

      function void note(cmd_type c);
         longint px, py, pz, cp, sp, cy, sy, h;
         longint unsigned sum, r, rr, yy, hz;
         int      st, lim, p;
         pose_type e;
         st = int'(angle_step);
         if (c.kind == KIND_LOAD) begin
            px = longint'(c.px); py = longint'(c.py); pz = longint'(c.pz);
            sum = longint'(px * px) + longint'(py * py) + longint'(pz * pz);
            r = int_sqrt(sum);
            if (r > 64'd2147483647) r = 64'd2147483647;
            if (r < load_min_radius) r = load_min_radius;
            radius = longint'(r);
            rr = r * r;
            yy = py * py;
            hz = (rr > yy) ? int_sqrt(rr - yy) : 0;
            yaw = heading(pz, px);
            p = heading(longint'(hz), py);
            if (p > int'(HALF_PI_Q13)) p = int'(HALF_PI_Q13);
            if (p < -int'(HALF_PI_Q13)) p = -int'(HALF_PI_Q13);
            pitch = p;
         end else if (c.kind == KIND_KEY) begin
            case (c.key)
               KEY_W_LO, KEY_W_UP: radius = (radius > zoom_step) ? radius - zoom_step : 0;
               KEY_S_LO, KEY_S_UP: begin
                  radius = radius + zoom_step;
                  if (radius > 64'd2147483647) radius = 64'd2147483647;
               end
               KEY_D_LO, KEY_D_UP: yaw = wrap(yaw + st);
               KEY_A_LO, KEY_A_UP: yaw = wrap(yaw - st);
               default: ;
            endcase
            if (radius < min_radius) radius = min_radius;
         end else if (c.kind == KIND_SPECIAL) begin
            lim = int'(pitch_limit);
            case (c.key)
               KEY_RIGHT: yaw = wrap(yaw + st);
               KEY_LEFT:  yaw = wrap(yaw - st);
               KEY_UP:    pitch = pitch + st;
               KEY_DOWN:  pitch = pitch - st;
               default: ;
            endcase
            if (pitch > lim) pitch = lim;
            if (pitch < -lim) pitch = -lim;
         end
         rotate(pitch, cp, sp);
         rotate(yaw, cy, sy);
         h = rshift_round(radius * cp, 30);
         e.cam_x  = 32'(clip32(rshift_round(h * sy, 30)));
         e.cam_y  = 32'(clip32(rshift_round(radius * sp, 30)));
         e.cam_z  = 32'(clip32(rshift_round(h * cy, 30)));
         e.radius = 31'(radius);
         e.yaw    = 16'(yaw);
         e.pitch  = 15'(pitch);
         pending.push_back(e);
      endfunction

      function void check(pose_type g);
         pose_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (g.cam_x !== e.cam_x) begin
            $error("cam_x expected %0d got %0d", e.cam_x, g.cam_x); errors++;
         end
         if (g.cam_y !== e.cam_y) begin
            $error("cam_y expected %0d got %0d", e.cam_y, g.cam_y); errors++;
         end
         if (g.cam_z !== e.cam_z) begin
            $error("cam_z expected %0d got %0d", e.cam_z, g.cam_z); errors++;
         end
         if (g.radius !== e.radius) begin
            $error("out_radius expected %0d got %0d", e.radius, g.radius); errors++;
         end
         if (g.yaw !== e.yaw) begin
            $error("out_yaw expected %0d got %0d", e.yaw, g.yaw); errors++;
         end
         if (g.pitch !== e.pitch) begin
            $error("out_pitch expected %0d got %0d", e.pitch, g.pitch); errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = KIND_NONE;
   logic [7:0]         req_key_code = 8'd0;
   logic signed [31:0] req_pos_x = 32'sd0;
   logic signed [31:0] req_pos_y = 32'sd0;
   logic signed [31:0] req_pos_z = 32'sd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_cam_x, rsp_cam_y, rsp_cam_z;
   logic [30:0]        rsp_out_radius;
   logic signed [15:0] rsp_out_yaw;
   logic signed [14:0] rsp_out_pitch;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = REG_ZOOM_STEP;
   logic [30:0]        csr_wdata = 31'd0;

   camera_scoreboard pose_board = new();
   bit  steady;
   int  cycles = 0;

   orbit_camera_position DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_key_code(req_key_code),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cam_x(rsp_cam_x), .rsp_cam_y(rsp_cam_y), .rsp_cam_z(rsp_cam_z),
      .rsp_out_radius(rsp_out_radius), .rsp_out_yaw(rsp_out_yaw),
      .rsp_out_pitch(rsp_out_pitch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      pose_type g;
      if (!reset && rsp_valid && rsp_ready) begin
         g.cam_x = rsp_cam_x; g.cam_y = rsp_cam_y; g.cam_z = rsp_cam_z;
         g.radius = rsp_out_radius; g.yaw = rsp_out_yaw; g.pitch = rsp_out_pitch;
         pose_board.check(g);
      end
   end

   // result side stalls
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = steady ? 0 : $urandom_range(0, 16);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send(cmd_type c);
      int n;
      n = steady ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= c.kind;
      req_key_code <= c.key;
      req_pos_x    <= c.px;
      req_pos_y    <= c.py;
      req_pos_z    <= c.pz;
      do @(posedge clock); while (!req_ready);
      pose_board.note(c);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pose_board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_regs(longint zs, longint st, longint lim, longint mr, longint lmr);
      longint v[5];
      v = '{zs, st, lim, mr, lmr};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= 31'(v[i]);
         @(posedge clock);
         pose_board.set_reg(3'(i), v[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cmd_type make(logic [1:0] k, logic [7:0] key,
                                    logic [31:0] x, logic [31:0] y, logic [31:0] z);
      cmd_type c;
      c.kind = k; c.key = key; c.px = x; c.py = y; c.pz = z;
      return c;
   endfunction

   function automatic logic [31:0] coord();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1, 2:    return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
         3:       return 32'($signed($urandom_range(0, 2 * 65536000)) - 65536000);
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_type rand_cmd();
      cmd_type c;
      logic [7:0] keys[8];
      logic [7:0] arrows[4];
      int r;
      keys   = '{KEY_W_LO, KEY_W_UP, KEY_S_LO, KEY_S_UP, KEY_D_LO, KEY_D_UP, KEY_A_LO, KEY_A_UP};
      arrows = '{KEY_LEFT, KEY_UP, KEY_RIGHT, KEY_DOWN};
      c = make(2'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom, $urandom);
      r = $urandom_range(0, 99);
      if (r < 25) begin
         c.kind = KIND_LOAD; c.px = coord(); c.py = coord(); c.pz = coord();
      end else if (r < 65) begin
         c.kind = KIND_KEY; c.key = keys[$urandom_range(0, 7)];
      end else if (r < 92) begin
         c.kind = KIND_SPECIAL; c.key = arrows[$urandom_range(0, 3)];
      end
      return c;
   endfunction

   initial begin
      cmd_type d[$];
      steady = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      d.push_back(make(KIND_KEY, KEY_W_LO, 0, 0, 0));
      d.push_back(make(KIND_LOAD, 0, 0, 0, 0));
      d.push_back(make(KIND_LOAD, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      d.push_back(make(KIND_LOAD, 0, 32'h80000000, 32'h80000000, 32'h80000000));
      d.push_back(make(KIND_LOAD, 0, 0, 32'h00030000, 0));
      d.push_back(make(KIND_LOAD, 0, 0, 32'hFFFD0000, 0));
      d.push_back(make(KIND_LOAD, 0, 32'hFFFF0000, 0, 32'hFFFF0000));
      d.push_back(make(KIND_LOAD, 0, 32'h00010000, 32'h00008000, 32'hFFFE0000));
      d.push_back(make(KIND_KEY, KEY_W_UP, 0, 0, 0));
      d.push_back(make(KIND_KEY, KEY_S_LO, 0, 0, 0));
      d.push_back(make(KIND_KEY, KEY_S_UP, 0, 0, 0));
      d.push_back(make(KIND_KEY, KEY_D_LO, 0, 0, 0));
      d.push_back(make(KIND_KEY, KEY_D_UP, 0, 0, 0));
      d.push_back(make(KIND_KEY, KEY_A_LO, 0, 0, 0));
      d.push_back(make(KIND_KEY, KEY_A_UP, 0, 0, 0));
      d.push_back(make(KIND_KEY, 8'hFF, 0, 0, 0));
      d.push_back(make(KIND_SPECIAL, KEY_RIGHT, 0, 0, 0));
      d.push_back(make(KIND_SPECIAL, KEY_LEFT, 0, 0, 0));
      for (int i = 0; i < 3; i++) d.push_back(make(KIND_SPECIAL, KEY_UP, 0, 0, 0));
      d.push_back(make(KIND_SPECIAL, KEY_DOWN, 0, 0, 0));
      d.push_back(make(KIND_SPECIAL, 8'd0, 0, 0, 0));
      d.push_back(make(KIND_NONE, KEY_W_LO, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
      foreach (d[i]) send(d[i]);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: load_regs(0, 0, 0, 0, 0);
            1: load_regs(64'h7FFFFFFF, 25735, 12868, 64'h7FFFFFFF, 64'h7FFFFFFF);
            2: load_regs(64'h7FFFFFFF, 25735, 12868, 0, 0);
            3: load_regs($urandom_range(0, 32'h7FFFFFFF), $urandom_range(0, 25735),
                         $urandom_range(0, 12868), $urandom_range(0, 32'h7FFFFFFF),
                         $urandom_range(0, 32'h7FFFFFFF));
            default: load_regs($urandom_range(0, 1 << 20), $urandom_range(0, 25735),
                               $urandom_range(0, 12868), $urandom_range(0, 1 << 18),
                               $urandom_range(0, 1 << 18));
         endcase
         for (int i = 0; i < 200; i++) begin
            if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
            send(rand_cmd());
         end
         steady = 0;
         drain();
      end

      if (pose_board.errors == 0 && pose_board.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ocp_pkg.sv
rtl/core/ocp_sqrt.sv
rtl/core/ocp_cordic.sv
rtl/core/orbit_camera_position.sv
rtl/core/ocp_checker.sv
tb/sv/testbench.sv
